// ===== design/cop_pkg.sv =====
package cop_pkg;

  localparam int ID_W  = 5;   // slot, first_id, second_id
  localparam int CNT_W = 6;   // entity_count
  localparam int RAD_W = 15;  // radius, unsigned Q15.0, same scale as positions

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ROT,
    S_FIN
  } st_t;

  // control of one compare step entering the pair unit
  typedef struct packed {
    logic            vld;
    logic            qual;  // both entries collide and j lies in the walked range
    logic            fin;   // end-of-query marker, no compare
    logic [ID_W-1:0] i;
    logic [ID_W-1:0] j;
  } a_ctl_t;

  // outcome of one compare step leaving the pair unit
  typedef struct packed {
    logic            vld;
    logic            hit;
    logic            fin;
    logic [ID_W-1:0] i;
    logic [ID_W-1:0] j;
  } cmp_res_t;

endpackage

// ===== design/cop_cell.sv =====
module cop_cell #(
  parameter int POS_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             shift,
  input  logic                             load,
  input  logic signed [POS_BITS-1:0]       ld_x,
  input  logic signed [POS_BITS-1:0]       ld_y,
  input  logic        [cop_pkg::RAD_W-1:0] ld_r,
  input  logic                             ld_f,
  input  logic signed [POS_BITS-1:0]       nb_x,
  input  logic signed [POS_BITS-1:0]       nb_y,
  input  logic        [cop_pkg::RAD_W-1:0] nb_r,
  input  logic                             nb_f,
  output logic signed [POS_BITS-1:0]       x,
  output logic signed [POS_BITS-1:0]       y,
  output logic        [cop_pkg::RAD_W-1:0] r,
  output logic                             f
);
  import cop_pkg::*;

  logic signed [POS_BITS-1:0] x_r;
  logic signed [POS_BITS-1:0] y_r;
  logic        [RAD_W-1:0]    r_r;
  logic                       f_r;

  // entry payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      x_r <= ld_x;
      y_r <= ld_y;
      r_r <= ld_r;
    end else if (shift) begin
      x_r <= nb_x;
      y_r <= nb_y;
      r_r <= nb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_r <= 1'b0;
    end else if (load) begin
      f_r <= ld_f;
    end else if (shift) begin
      f_r <= nb_f;
    end
  end

  assign x = x_r;
  assign y = y_r;
  assign r = r_r;
  assign f = f_r;

endmodule

// ===== design/cop_pair_unit.sv =====
module cop_pair_unit #(
  parameter int POS_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             adv,
  input  cop_pkg::a_ctl_t                  a_ctl,
  input  logic signed [POS_BITS-1:0]       row_x,
  input  logic signed [POS_BITS-1:0]       row_y,
  input  logic        [cop_pkg::RAD_W-1:0] row_r,
  input  logic signed [POS_BITS-1:0]       col_x,
  input  logic signed [POS_BITS-1:0]       col_y,
  input  logic        [cop_pkg::RAD_W-1:0] col_r,
  output cop_pkg::cmp_res_t                res
);
  import cop_pkg::*;

  localparam int SQ_W = 2 * POS_BITS;
  localparam int RS_W = RAD_W + 1;
  localparam int SW_A = SQ_W + 1;
  localparam int SW_B = 2 * RS_W;
  localparam int SW   = (SW_A > SW_B) ? SW_A : SW_B;

  logic signed [POS_BITS:0]   ddx;
  logic signed [POS_BITS:0]   ddy;
  logic        [POS_BITS-1:0] adx;
  logic        [POS_BITS-1:0] ady;

  a_ctl_t                s1_ctl_r;
  logic [POS_BITS-1:0]   s1_dx_r;
  logic [POS_BITS-1:0]   s1_dy_r;
  logic [RS_W-1:0]       s1_rs_r;

  a_ctl_t                s2_ctl_r;
  logic [SQ_W-1:0]       s2_sx_r;
  logic [SQ_W-1:0]       s2_sy_r;
  logic [SW_B-1:0]       s2_sr_r;

  logic [SW-1:0]         dist_sq;
  logic [SW-1:0]         lim_sq;
  cmp_res_t              res_nxt;
  cmp_res_t              res_r;

  // stage 1: magnitudes of the offsets and the radius sum
  assign ddx = $signed({row_x[POS_BITS-1], row_x}) - $signed({col_x[POS_BITS-1], col_x});
  assign ddy = $signed({row_y[POS_BITS-1], row_y}) - $signed({col_y[POS_BITS-1], col_y});
  assign adx = ddx[POS_BITS] ? POS_BITS'(-ddx) : ddx[POS_BITS-1:0];
  assign ady = ddy[POS_BITS] ? POS_BITS'(-ddy) : ddy[POS_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
      s2_ctl_r <= '0;
    end else if (adv) begin
      s1_ctl_r <= a_ctl;
      s2_ctl_r <= s1_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_dx_r <= adx;
      s1_dy_r <= ady;
      s1_rs_r <= RS_W'(row_r) + RS_W'(col_r);
      // stage 2: squares
      s2_sx_r <= SQ_W'(s1_dx_r) * SQ_W'(s1_dx_r);
      s2_sy_r <= SQ_W'(s1_dy_r) * SQ_W'(s1_dy_r);
      s2_sr_r <= SW_B'(s1_rs_r) * SW_B'(s1_rs_r);
    end
  end

  // stage 3: strict compare of squared distance against squared radius sum
  assign dist_sq = SW'(s2_sx_r) + SW'(s2_sy_r);
  assign lim_sq  = SW'(s2_sr_r);

  always_comb begin
    res_nxt.vld = s2_ctl_r.vld;
    res_nxt.hit = s2_ctl_r.qual && (dist_sq < lim_sq);
    res_nxt.fin = s2_ctl_r.fin;
    res_nxt.i   = s2_ctl_r.i;
    res_nxt.j   = s2_ctl_r.j;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= '0;
    end else if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

// ===== design/cop_collector.sv =====
module cop_collector (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cop_pkg::cmp_res_t              res,
  output logic                           adv,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic                           out_hit,
  output logic [cop_pkg::ID_W-1:0]       out_first,
  output logic [cop_pkg::ID_W-1:0]       out_second,
  output logic                           out_last
);
  import cop_pkg::*;

  logic            pend_v_r;
  logic            pend_v_nxt;
  logic [ID_W-1:0] pend_j_r;
  logic [ID_W-1:0] pend_j_nxt;

  logic            out_v_r;
  logic            out_v_nxt;
  logic            out_hit_r;
  logic            out_hit_nxt;
  logic [ID_W-1:0] out_i_r;
  logic [ID_W-1:0] out_i_nxt;
  logic [ID_W-1:0] out_j_r;
  logic [ID_W-1:0] out_j_nxt;
  logic            out_last_r;
  logic            out_last_nxt;
  logic            push;

  assign adv = !out_v_r || out_tready;

  // one hit is held back until the next hit or the end marker tells if it is the last
  always_comb begin
    pend_v_nxt   = pend_v_r;
    pend_j_nxt   = pend_j_r;
    push         = 1'b0;
    out_hit_nxt  = out_hit_r;
    out_i_nxt    = out_i_r;
    out_j_nxt    = out_j_r;
    out_last_nxt = out_last_r;
    if (adv && res.vld) begin
      if (res.fin) begin
        push         = 1'b1;
        out_hit_nxt  = pend_v_r;
        out_i_nxt    = res.i;
        out_j_nxt    = pend_v_r ? pend_j_r : '0;
        out_last_nxt = 1'b1;
        pend_v_nxt   = 1'b0;
      end else if (res.hit) begin
        push         = pend_v_r;
        out_hit_nxt  = 1'b1;
        out_i_nxt    = res.i;
        out_j_nxt    = pend_j_r;
        out_last_nxt = 1'b0;
        pend_v_nxt   = 1'b1;
        pend_j_nxt   = res.j;
      end
    end
    if (push) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_j_r   <= pend_j_nxt;
    out_hit_r  <= out_hit_nxt;
    out_i_r    <= out_i_nxt;
    out_j_r    <= out_j_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_hit    = out_hit_r;
  assign out_first  = out_i_r;
  assign out_second = out_j_r;
  assign out_last   = out_last_r;

endmodule

// ===== design/circle_overlap_pair_finder.sv =====
// channel | dir | tdata fields (low bit up)                           | tuser   | tlast
// in_     | in  | slot, pos_x, pos_y, radius, collides, entity_count   | command | -
// out_    | out | first_id, second_id                                 | hit     | last
//
// a load transfer writes one cell
// a query rotates the entity chain through all MAX_SLOTS cells (one step per cycle while
// the output is not stalled), then issues the end marker before in_tready returns
// a result leaves after the step that closes it: the next hit or the end marker
// a stalled output freezes the chain and the compare pipeline
// reset clears the collide flags; positions and radii hold garbage until loaded
module circle_overlap_pair_finder #(
  parameter int MAX_SLOTS = 32,
  parameter int POS_BITS  = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // slot[4:0], pos_x, pos_y, radius[14:0], collides, entity_count[5:0], zero pad
  input  logic [((cop_pkg::ID_W + 2 * POS_BITS + cop_pkg::RAD_W + 1 + cop_pkg::CNT_W + 7)
                 / 8) * 8 - 1:0] in_tdata,
  // command
  input  logic                in_tuser,
  output logic                out_tvalid,
  input  logic                out_tready,
  // first_id[4:0], second_id[9:5], zero pad
  output logic [15:0]         out_tdata,
  // hit
  output logic                out_tuser,
  output logic                out_tlast
);
  import cop_pkg::*;

  // input field offsets inside tdata
  localparam int OFF_X   = ID_W;
  localparam int OFF_Y   = OFF_X + POS_BITS;
  localparam int OFF_R   = OFF_Y + POS_BITS;
  localparam int OFF_C   = OFF_R + RAD_W;
  localparam int OFF_N   = OFF_C + 1;
  localparam int IN_BITS = OFF_N + CNT_W;

  localparam int K_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int W   = (K_W > CNT_W) ? K_W : CNT_W;
  localparam logic [K_W-1:0] K_LAST = K_W'(MAX_SLOTS - 1);

  // unpacked input fields
  logic        [ID_W-1:0]     in_slot;
  logic signed [POS_BITS-1:0] in_x;
  logic signed [POS_BITS-1:0] in_y;
  logic        [RAD_W-1:0]    in_r;
  logic                       in_c;
  logic        [CNT_W-1:0]    in_n;

  assign in_slot = in_tdata[ID_W-1:0];
  assign in_x    = $signed(in_tdata[OFF_Y-1:OFF_X]);
  assign in_y    = $signed(in_tdata[OFF_R-1:OFF_Y]);
  assign in_r    = in_tdata[OFF_C-1:OFF_R];
  assign in_c    = in_tdata[OFF_C];
  assign in_n    = in_tdata[IN_BITS-1:OFF_N];

  // entity chain, cell 0 is the head seen by the pair unit
  logic signed [POS_BITS-1:0] cx [MAX_SLOTS];
  logic signed [POS_BITS-1:0] cy [MAX_SLOTS];
  logic        [RAD_W-1:0]    cr [MAX_SLOTS];
  logic                       cf [MAX_SLOTS];
  logic        [MAX_SLOTS-1:0] ld_en;

  logic            load_fire;
  logic [W-1:0]    in_slot_ext;
  logic            shift;
  logic            adv;

  st_t             state_r;
  st_t             state_nxt;
  logic [K_W-1:0]  k_r;
  logic [K_W-1:0]  k_nxt;
  logic [W-1:0]    k_ext;
  logic [ID_W-1:0] q_slot_r;
  logic [CNT_W-1:0] q_cnt_r;
  logic            q_ld;
  logic [W-1:0]    q_slot_ext;
  logic [W-1:0]    q_cnt_ext;

  // queried row, captured as it passes the head
  logic signed [POS_BITS-1:0] row_x_r;
  logic signed [POS_BITS-1:0] row_y_r;
  logic        [RAD_W-1:0]    row_r_r;
  logic                       row_f_r;
  logic                       row_ld;

  a_ctl_t   a_ctl;
  cmp_res_t res;

  logic            o_hit;
  logic [ID_W-1:0] o_first;
  logic [ID_W-1:0] o_second;
  logic            o_last;

  assign load_fire   = in_tvalid && in_tready && (in_tuser == CMD_LOAD);
  assign in_slot_ext = W'(in_slot);
  assign k_ext       = W'(k_r);
  assign q_slot_ext  = W'(q_slot_r);
  assign q_cnt_ext   = W'(q_cnt_r);

  for (genvar c = 0; c < MAX_SLOTS; c++) begin : g_cell
    localparam int NB = (c == MAX_SLOTS - 1) ? 0 : c + 1;
    // a slot beyond the chain matches no cell and is dropped
    assign ld_en[c] = load_fire && (in_slot_ext == W'(c));
    cop_cell #(
      .POS_BITS(POS_BITS)
    ) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .shift(shift),
      .load (ld_en[c]),
      .ld_x (in_x),
      .ld_y (in_y),
      .ld_r (in_r),
      .ld_f (in_c),
      .nb_x (cx[NB]),
      .nb_y (cy[NB]),
      .nb_r (cr[NB]),
      .nb_f (cf[NB]),
      .x    (cx[c]),
      .y    (cy[c]),
      .r    (cr[c]),
      .f    (cf[c])
    );
  end

  // sequencer: idle, one full rotation of the chain, then the end marker
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    in_tready = 1'b0;
    shift     = 1'b0;
    q_ld      = 1'b0;
    row_ld    = 1'b0;
    a_ctl     = '0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid && (in_tuser == CMD_QUERY)) begin
          q_ld      = 1'b1;
          k_nxt     = '0;
          state_nxt = S_ROT;
        end
      end
      S_ROT: begin
        if (adv) begin
          // the head holds entry k before this shift
          shift      = 1'b1;
          a_ctl.vld  = 1'b1;
          a_ctl.qual = row_f_r && cf[0] && (k_ext > q_slot_ext) && (k_ext < q_cnt_ext);
          a_ctl.i    = q_slot_r;
          a_ctl.j    = k_ext[ID_W-1:0];
          row_ld     = (k_ext == q_slot_ext);
          if (k_r == K_LAST) begin
            state_nxt = S_FIN;
          end else begin
            k_nxt = k_r + K_W'(1);
          end
        end
      end
      S_FIN: begin
        if (adv) begin
          a_ctl.vld = 1'b1;
          a_ctl.fin = 1'b1;
          a_ctl.i   = q_slot_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
      row_f_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      if (q_ld) begin
        row_f_r <= 1'b0;
      end else if (row_ld) begin
        row_f_r <= cf[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_ld) begin
      q_slot_r <= in_slot;
      q_cnt_r  <= in_n;
    end
    if (row_ld) begin
      row_x_r <= cx[0];
      row_y_r <= cy[0];
      row_r_r <= cr[0];
    end
  end

  cop_pair_unit #(
    .POS_BITS(POS_BITS)
  ) u_pair (
    .clk  (clk),
    .rst_n(rst_n),
    .adv  (adv),
    .a_ctl(a_ctl),
    .row_x(row_x_r),
    .row_y(row_y_r),
    .row_r(row_r_r),
    .col_x(cx[0]),
    .col_y(cy[0]),
    .col_r(cr[0]),
    .res  (res)
  );

  cop_collector u_coll (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .adv       (adv),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_hit   (o_hit),
    .out_first (o_first),
    .out_second(o_second),
    .out_last  (o_last)
  );

  assign out_tdata = {6'b0, o_second, o_first};
  assign out_tuser = o_hit;
  assign out_tlast = o_last;

`ifndef SYNTHESIS
  // a reported pair always names a higher second index
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (o_second > o_first))
    else $error("pair reported with second_id not above first_id");

  // a result without a pair closes its query
  a_nohit_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> out_tlast)
    else $error("no-hit result not marked last");

  // every rotation starts with the head at entry zero
  a_rot_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROT && $past(state_r) == S_IDLE) |-> (k_r == '0))
    else $error("rotation started off entry zero");

  // the chain never moves while a load is taken
  a_no_shift_load: assert property (@(posedge clk) disable iff (!rst_n)
    load_fire |-> !shift)
    else $error("load taken during rotation");
`endif

endmodule

// ===== sim/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cop_pkg::*;

  localparam int MAX_SLOTS   = 32;
  localparam int POS_BITS    = 16;
  localparam int IN_BITS     = 64;
  localparam int N_DIR       = 25;
  localparam int N_RANDOM    = 280;
  localparam int QUIET_TAIL  = 40;    // last random transfers run with no idling
  localparam int LONG_HOLD   = 300;   // receiver hold-off, in cycles
  localparam int DRAIN_WAIT  = 48;    // query walk plus pipeline, with margin
  localparam int CYCLE_LIMIT = 400000;

  // one result of a pair query
  typedef struct {
    bit              hit;
    bit [ID_W-1:0]   first_id;
    bit [ID_W-1:0]   second_id;
    bit              last;
  } pair_rec_t;

  // shadow of one entity cell
  typedef struct {
    logic signed [POS_BITS-1:0] x;
    logic signed [POS_BITS-1:0] y;
    logic [RAD_W-1:0]           r;
    bit                         col;
  } entity_t;

  // one row of the directed table
  typedef struct {
    bit                         cmd;
    bit [ID_W-1:0]              slot;
    logic signed [POS_BITS-1:0] x;
    logic signed [POS_BITS-1:0] y;
    logic [RAD_W-1:0]           r;
    bit                         col;
    bit [CNT_W-1:0]             cnt;
    bit                         typed;
    pair_rec_t                  want;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  // slot[4:0], pos_x[20:5], pos_y[36:21], radius[51:37], collides[52],
  // entity_count[58:53], zero pad
  logic [IN_BITS-1:0]  in_tdata;
  // command
  logic                in_tuser;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  // first_id[4:0], second_id[9:5], zero pad
  logic [15:0]         out_tdata;
  // hit
  logic                out_tuser;
  logic                out_tlast;

  entity_t   ent_table [MAX_SLOTS];
  pair_rec_t pair_queue [$];
  dir_row_t  dir_table [N_DIR];

  int  cycle_count    = 0;
  int  mismatch_count = 0;
  int  results_seen   = 0;
  int  hits_seen      = 0;
  int  loads_sent     = 0;
  int  queries_sent   = 0;
  int  rand_sent      = 0;
  bit  quiet          = 1'b0;   // no idling on either side
  bit  hold_req       = 1'b0;   // asks the receiver for one long hold-off

  circle_overlap_pair_finder #(
    .MAX_SLOTS(MAX_SLOTS),
    .POS_BITS (POS_BITS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // exact circle test on the shadow table, 64-bit so nothing wraps
  function automatic bit circles_overlap(int a, int b);
    longint rsum;
    longint dx;
    longint dy;
    rsum = longint'(ent_table[a].r) + longint'(ent_table[b].r);
    dx = longint'(ent_table[a].x) - longint'(ent_table[b].x);
    dy = longint'(ent_table[a].y) - longint'(ent_table[b].y);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    if (dx >= rsum || dy >= rsum) return 1'b0;
    return (dx * dx + dy * dy) < (rsum * rsum);
  endfunction

  // queue every pair found for one row, or the single empty result
  function automatic void predict_pairs(bit [ID_W-1:0] row, bit [CNT_W-1:0] cnt);
    int        limit;
    int        found;
    pair_rec_t rec;
    limit = (cnt > MAX_SLOTS) ? MAX_SLOTS : int'(cnt);
    found = 0;
    if (ent_table[row].col) begin
      for (int j = int'(row) + 1; j < limit; j++) begin
        if (ent_table[j].col && circles_overlap(int'(row), j)) begin
          rec.hit       = 1'b1;
          rec.first_id  = row;
          rec.second_id = ID_W'(j);
          rec.last      = 1'b0;
          pair_queue.push_back(rec);
          found++;
        end
      end
    end
    if (found == 0) begin
      rec.hit       = 1'b0;
      rec.first_id  = row;
      rec.second_id = '0;
      rec.last      = 1'b1;
      pair_queue.push_back(rec);
    end else begin
      pair_queue[pair_queue.size() - 1].last = 1'b1;
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (mismatch_count < 50)
      $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want,
               cycle_count);
    mismatch_count++;
  endtask

  // offer one item, wait for its transfer, then update the shadow state
  task automatic send_item(bit cmd, bit [ID_W-1:0] slot,
                           logic signed [POS_BITS-1:0] px, logic signed [POS_BITS-1:0] py,
                           logic [RAD_W-1:0] rad, bit col, bit [CNT_W-1:0] cnt,
                           bit typed, pair_rec_t want);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {5'b0, cnt, col, rad, py, px, slot};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (cmd == CMD_LOAD) begin
      ent_table[slot].x   = px;
      ent_table[slot].y   = py;
      ent_table[slot].r   = rad;
      ent_table[slot].col = col;
      loads_sent++;
    end else begin
      if (typed) pair_queue.push_back(want);
      else predict_pairs(slot, cnt);
      queries_sent++;
    end
  endtask

  // random item outside any well-formed scene
  task automatic send_noise();
    pair_rec_t none;
    none = '{default: 0};
    send_item($urandom_range(0, 1) ? CMD_QUERY : CMD_LOAD, ID_W'($urandom_range(0, 31)),
              POS_BITS'($urandom_range(0, 65535)), POS_BITS'($urandom_range(0, 65535)),
              RAD_W'($urandom_range(0, 32767)), bit'($urandom_range(0, 1)),
              CNT_W'($urandom_range(0, 63)), 1'b0, none);
  endtask

  function automatic logic signed [POS_BITS-1:0] clamp_pos(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return POS_BITS'(v);
  endfunction

  // receiver: random stall bursts, one long hold-off on request
  int ready_gap = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left  = hold_left - 1;
      out_tready <= 1'b0;
    end else if (ready_gap > 0) begin
      ready_gap  = ready_gap - 1;
      out_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      ready_gap  = $urandom_range(0, 3);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // result checker: every transfer against the oldest expectation
  always @(posedge clk) begin
    pair_rec_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pair_queue.size() == 0) begin
        report_mismatch("unexpected result, first_id", int'(out_tdata[4:0]), -1);
      end else begin
        want = pair_queue.pop_front();
        if (out_tuser !== want.hit)
          report_mismatch("hit", int'(out_tuser), int'(want.hit));
        if (out_tdata[4:0] !== want.first_id)
          report_mismatch("first_id", int'(out_tdata[4:0]), int'(want.first_id));
        if (out_tdata[9:5] !== want.second_id)
          report_mismatch("second_id", int'(out_tdata[9:5]), int'(want.second_id));
        if (out_tlast !== want.last)
          report_mismatch("last", int'(out_tlast), int'(want.last));
        results_seen++;
        if (out_tuser) hits_seen++;
      end
    end
  end

  // run-away guard
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d results still expected", cycle_count,
             pair_queue.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    pair_rec_t none;
    int        n;
    int        scene;
    int        cx;
    int        cy;
    int        spread;
    int        rmax;
    bit [CNT_W-1:0] cnt;

    none = '{default: 0};
    for (int k = 0; k < MAX_SLOTS; k++) ent_table[k] = '{x: 0, y: 0, r: 0, col: 0};

    // directed rows: typed expectations only for the obvious empty results
    //               cmd        slot  x       y       r      col cnt typed  hit f   s  last
    dir_table[0]  = '{CMD_QUERY,  0,      0,      0,     0, 0, 32, 1, '{0,  0, 0, 1}};
    dir_table[1]  = '{CMD_QUERY, 31,      0,      0,     0, 0, 63, 1, '{0, 31, 0, 1}};
    dir_table[2]  = '{CMD_LOAD,   0,      0,      0,   100, 1,  0, 0, '{0,  0, 0, 0}};
    dir_table[3]  = '{CMD_LOAD,   1,    150,      0,    60, 1,  0, 0, '{0,  0, 0, 0}};
    // touching exactly: distance equals the radius sum, no hit
    dir_table[4]  = '{CMD_LOAD,   2,      0,    160,    60, 1,  0, 0, '{0,  0, 0, 0}};
    dir_table[5]  = '{CMD_LOAD,   3, -32768, -32768, 32767, 1,  0, 0, '{0,  0, 0, 0}};
    dir_table[6]  = '{CMD_LOAD,   4,  32767,  32767, 32767, 1,  0, 0, '{0,  0, 0, 0}};
    // overlapping position but no collision component
    dir_table[7]  = '{CMD_LOAD,   5,      0,      0,     0, 0,  0, 0, '{0,  0, 0, 0}};
    dir_table[8]  = '{CMD_LOAD,   6,     10,     10,    10, 1,  0, 0, '{0,  0, 0, 0}};
    dir_table[9]  = '{CMD_QUERY,  0,      0,      0,     0, 0,  7, 0, '{0,  0, 0, 0}};
    // empty walk ranges
    dir_table[10] = '{CMD_QUERY,  0,      0,      0,     0, 0,  1, 1, '{0,  0, 0, 1}};
    dir_table[11] = '{CMD_QUERY,  0,      0,      0,     0, 0,  0, 1, '{0,  0, 0, 1}};
    // queried row does not collide
    dir_table[12] = '{CMD_QUERY,  5,      0,      0,     0, 0, 32, 1, '{0,  5, 0, 1}};
    dir_table[13] = '{CMD_QUERY,  3,      0,      0,     0, 0,  5, 0, '{0,  0, 0, 0}};
    // coincident points, zero radii
    dir_table[14] = '{CMD_LOAD,   8, -32768, -32768,     0, 1,  0, 0, '{0,  0, 0, 0}};
    dir_table[15] = '{CMD_LOAD,   9, -32768, -32768,     0, 1,  0, 0, '{0,  0, 0, 0}};
    dir_table[16] = '{CMD_QUERY,  8,      0,      0,     0, 0, 10, 0, '{0,  0, 0, 0}};
    // count above the table size saturates
    dir_table[17] = '{CMD_QUERY,  3,      0,      0,     0, 0, 40, 0, '{0,  0, 0, 0}};
    dir_table[18] = '{CMD_LOAD,  31,      0,      0, 32767, 1,  0, 0, '{0,  0, 0, 0}};
    dir_table[19] = '{CMD_QUERY,  0,      0,      0,     0, 0, 32, 0, '{0,  0, 0, 0}};
    dir_table[20] = '{CMD_QUERY, 30,      0,      0,     0, 0, 32, 1, '{0, 30, 0, 1}};
    dir_table[21] = '{CMD_QUERY, 31,      0,      0,     0, 0, 32, 1, '{0, 31, 0, 1}};
    // overwrite an entry with its collision flag cleared
    dir_table[22] = '{CMD_LOAD,   1,    150,      0,    60, 0,  0, 0, '{0,  0, 0, 0}};
    dir_table[23] = '{CMD_QUERY,  0,      0,      0,     0, 0, 32, 0, '{0,  0, 0, 0}};
    dir_table[24] = '{CMD_QUERY,  2,      0,      0,     0, 0, 32, 0, '{0,  0, 0, 0}};

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tuser  = 1'b0;
    in_tdata  = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int k = 0; k < N_DIR; k++)
      send_item(dir_table[k].cmd, dir_table[k].slot, dir_table[k].x, dir_table[k].y,
                dir_table[k].r, dir_table[k].col, dir_table[k].cnt, dir_table[k].typed,
                dir_table[k].want);

    // random scenes: load a cluster of entities, then query its rows in order
    scene = 0;
    while (rand_sent < N_RANDOM) begin
      // the long receiver hold-off lands while a scene is streaming in
      if (scene == 2) hold_req = 1'b1;
      // sender pause until the block has drained completely
      if (scene == 5) begin
        in_tvalid <= 1'b0;
        do @(posedge clk); while (pair_queue.size() != 0);
      end
      n = (scene == 1 || $urandom_range(0, 9) == 0) ? MAX_SLOTS : $urandom_range(2, 10);
      cx = $urandom_range(0, 65535) - 32768;
      cy = $urandom_range(0, 65535) - 32768;
      spread = ($urandom_range(0, 3) == 0) ? 8000 : 600;
      rmax = ($urandom_range(0, 7) == 0) ? 32767 : spread / 2;

      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 9) == 0) send_noise();
        else
          send_item(CMD_LOAD, ID_W'(k),
                    clamp_pos(cx + $urandom_range(0, 2 * spread) - spread),
                    clamp_pos(cy + $urandom_range(0, 2 * spread) - spread),
                    RAD_W'($urandom_range(0, rmax)), bit'($urandom_range(0, 4) != 0),
                    '0, 1'b0, none);
        rand_sent++;
        quiet = (rand_sent >= N_RANDOM - QUIET_TAIL);
      end
      for (int k = 0; k < n; k++) begin
        cnt = ($urandom_range(0, 7) == 0) ? CNT_W'($urandom_range(0, 63)) : CNT_W'(n);
        if ($urandom_range(0, 9) == 0) send_noise();
        else
          send_item(CMD_QUERY, ID_W'(k), POS_BITS'($urandom_range(0, 65535)),
                    POS_BITS'($urandom_range(0, 65535)), RAD_W'($urandom_range(0, 32767)),
                    bit'($urandom_range(0, 1)), cnt, 1'b0, none);
        rand_sent++;
        quiet = (rand_sent >= N_RANDOM - QUIET_TAIL);
      end
      scene++;
    end
    in_tvalid <= 1'b0;

    // drain, then let any stray result show up
    while (pair_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d loads and %0d pair queries over %0d random scenes", loads_sent,
             queries_sent, scene);
    $display("checked %0d results (%0d overlapping pairs), %0d mismatches", results_seen,
             hits_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
